### rtl/core/lrs48_pkg.sv
package lrs48_pkg;

  // Fixed formats of the stream fields and the configuration registers.
  localparam int SAMPLE_W        = 16;
  localparam int RATE_W          = 18;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 18;

  // Default number of fraction bits of the phase accumulator.
  localparam int PHASE_FRAC_BITS = 16;

  // Output sample rate in Hz, and the largest number of outputs per input frame.
  localparam int TARGET_RATE_HZ  = 48000;
  localparam int MAX_OUT         = 9;
  localparam int OUT_CNT_W       = 4;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_INPUT = 2'd1;

  // One classified input frame on its way from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_l;
    logic signed [SAMPLE_W-1:0] sample_r;
    logic                       pass_through;
  } frame_t;

endpackage

### rtl/core/linear_resampler_to_48k_stereo_top.sv
// Linear-interpolation sample-rate converter to 48 kHz stereo. Each request on the
// input stream carries one frame of two signed 16-bit samples (left in the low half,
// right in the high half; in mono mode the left sample feeds both channels). At a
// source rate of 48000 Hz, or zero, every frame passes straight through as one output
// request with tlast set. At any other rate a Q3.F phase accumulator advances by
// rate/48000 per output, each output is prev + (cur - prev) * phase truncated toward
// zero, and the last output made for a frame carries tlast; a frame may also give no
// output at all, and never more than nine. A pass-through frame goes from the queue
// straight to the output register; every interpolated output goes through the
// multiply state and then the output state of the back end, where the add is done;
// a frame with no output only moves the phase and the previous samples on. A
// two-entry queue between the front end and the back end lets new frames be taken
// while outputs still wait on the output stream. Writing source_rate forms the new
// phase step with one multiply by a constant reciprocal in the cycle after the
// write, and input requests are held off in that cycle. A write to either mapped
// register clears the phase and the previous samples; writes are meant to be made
// only while no frame is in flight.
module linear_resampler_to_48k_stereo_top #(
  parameter int PHASE_FRAC_BITS = lrs48_pkg::PHASE_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [lrs48_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrs48_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // From bit 0 up: left_sample[15:0], right_sample[15:0].
  input  logic [2*lrs48_pkg::SAMPLE_W-1:0]     in_tdata,
  // Output stream; tlast marks the final output of an input frame.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // From bit 0 up: out_left[15:0], out_right[15:0].
  output logic [2*lrs48_pkg::SAMPLE_W-1:0]     out_tdata,
  output logic                                 out_tlast
);

  lrs48_pkg::frame_t      q_wdata;
  lrs48_pkg::frame_t      q_rdata;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic [PHASE_FRAC_BITS+2:0] step;
  logic                   clear_state;

  // The front end holds the registers, forms the phase step and classifies frames.
  lrs48_front #(
    .PF (PHASE_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .step        (step),
    .clear_state (clear_state)
  );

  lrs48_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The back end walks the phase and interpolates each output.
  lrs48_back #(
    .PF (PHASE_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .step        (step),
    .clear_state (clear_state),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

### rtl/core/lrs48_front.sv
module lrs48_front #(
  parameter int PF = lrs48_pkg::PHASE_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lrs48_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrs48_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [2*lrs48_pkg::SAMPLE_W-1:0]     in_tdata,
  input  logic                                 q_full,
  output logic                                 q_push,
  output lrs48_pkg::frame_t                    q_wdata,
  output logic [PF+2:0]                        step,
  output logic                                 clear_state
);

  // The output rate is an odd factor times a power of two. The step is the rate
  // times the rounded-up reciprocal of the odd factor; the shift is wide enough
  // that the product floors to the exact quotient for every 18-bit rate.
  localparam int RATE_POW2   = 7;
  localparam int RATE_ODD    = lrs48_pkg::TARGET_RATE_HZ >> RATE_POW2;
  localparam int RECIP_SHIFT = lrs48_pkg::RATE_W + $clog2(RATE_ODD);
  localparam int RECIP_EXP   = RECIP_SHIFT + PF - RATE_POW2;
  localparam int RECIP_W     = RECIP_EXP - $clog2(RATE_ODD) + 1;
  localparam int PROD_W      = lrs48_pkg::RATE_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_EXP) + 64'(RATE_ODD - 1)) / 64'(RATE_ODD);

  logic [lrs48_pkg::RATE_W-1:0] rate_r;
  logic                         stereo_r;
  logic [PF+2:0]                step_r;
  logic                         busy_r;

  logic [lrs48_pkg::RATE_W-1:0] new_rate;
  logic [lrs48_pkg::RATE_W-1:0] rate_eff;
  logic [PROD_W-1:0]            step_prod;

  // A zero rate behaves as the output rate.
  assign new_rate  = cfg_wdata[lrs48_pkg::RATE_W-1:0];
  assign rate_eff  = (rate_r == '0) ? lrs48_pkg::RATE_W'(lrs48_pkg::TARGET_RATE_HZ) : rate_r;
  assign step_prod = PROD_W'(rate_eff) * PROD_W'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= lrs48_pkg::RATE_W'(lrs48_pkg::TARGET_RATE_HZ);
      stereo_r <= 1'b1;
      step_r   <= {3'b001, {PF{1'b0}}};
      busy_r   <= 1'b0;
    end else begin
      // The step is loaded from the new rate in the cycle after a rate write.
      busy_r <= cfg_we && (cfg_index == lrs48_pkg::REG_SOURCE_RATE);
      if (busy_r) begin
        step_r <= step_prod[RECIP_SHIFT +: PF + 3];
      end
      if (cfg_we) begin
        case (cfg_index)
          lrs48_pkg::REG_SOURCE_RATE: begin
            rate_r <= new_rate;
          end
          lrs48_pkg::REG_STEREO_INPUT: begin
            stereo_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    clear_state = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        lrs48_pkg::REG_SOURCE_RATE,
        lrs48_pkg::REG_STEREO_INPUT: clear_state = 1'b1;
        default:                     clear_state = 1'b0;
      endcase
    end
  end

  assign in_tready = !busy_r && !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign step      = step_r;

  // Classify the frame: mono copies the left sample; a zero rate or the output rate passes through.
  assign q_wdata.sample_l     = in_tdata[lrs48_pkg::SAMPLE_W-1:0];
  assign q_wdata.sample_r     = stereo_r ? in_tdata[2*lrs48_pkg::SAMPLE_W-1:lrs48_pkg::SAMPLE_W]
                                         : in_tdata[lrs48_pkg::SAMPLE_W-1:0];
  assign q_wdata.pass_through = (rate_r == '0) ||
                                (rate_r == lrs48_pkg::RATE_W'(lrs48_pkg::TARGET_RATE_HZ));

endmodule

### rtl/core/lrs48_queue.sv
module lrs48_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lrs48_pkg::frame_t wdata,
  output logic              full,
  input  logic              pop,
  output lrs48_pkg::frame_t rdata,
  output logic              empty
);

  localparam int DEPTH = lrs48_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrs48_pkg::frame_t entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/lrs48_back.sv
module lrs48_back #(
  parameter int PF = lrs48_pkg::PHASE_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  lrs48_pkg::frame_t                q_rdata,
  output logic                             q_pop,
  input  logic [PF+2:0]                    step,
  input  logic                             clear_state,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*lrs48_pkg::SAMPLE_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int SW = lrs48_pkg::SAMPLE_W;
  localparam int PW = SW + PF + 3;
  localparam int AW = SW + PF + 3;
  localparam int CW = lrs48_pkg::OUT_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                state_r;
  logic [PF+2:0]         phase_r;
  logic signed [SW-1:0]  prev_left_r;
  logic signed [SW-1:0]  prev_right_r;
  logic signed [SW-1:0]  cur_left_r;
  logic signed [SW-1:0]  cur_right_r;
  logic signed [PW-1:0]  prod_left_r;
  logic signed [PW-1:0]  prod_right_r;
  logic [CW-1:0]         cnt_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_left_r;
  logic signed [SW-1:0]  out_right_r;
  logic                  out_last_r;

  logic                  slot_free;
  logic                  emit;
  logic                  phase_ge_one;
  logic [PF+2:0]         phase_nxt;
  logic                  nxt_ge_one;
  logic                  final_out;
  logic signed [SW:0]    diff_left;
  logic signed [SW:0]    diff_right;
  logic signed [PF+1:0]  phase_frac;
  logic signed [SW-1:0]  lerp_left;
  logic signed [SW-1:0]  lerp_right;

  // Prev plus the scaled difference, divided by one with truncation toward zero.
  function automatic logic signed [SW-1:0] lerp_finish(
    input logic signed [SW-1:0] prev,
    input logic signed [PW-1:0] prod
  );
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] biased;
    logic signed [AW-1:0] shifted;
    acc     = (AW'(prev) <<< PF) + AW'(prod);
    biased  = acc + $signed({{(AW-PF){1'b0}}, {PF{acc[AW-1]}}});
    shifted = biased >>> PF;
    return shifted[SW-1:0];
  endfunction

  assign slot_free    = !out_valid_r || out_tready;
  assign q_pop        = (state_r == S_IDLE) && !q_empty && slot_free && !clear_state;
  assign emit         = (q_pop && q_rdata.pass_through) ||
                        ((state_r == S_OUT) && slot_free && !clear_state);
  assign phase_ge_one = (phase_r[PF+2:PF] != 3'b000);
  assign phase_nxt    = phase_r + step;
  assign nxt_ge_one   = (phase_nxt[PF+2:PF] != 3'b000);
  assign final_out    = nxt_ge_one || (cnt_r == CW'(lrs48_pkg::MAX_OUT - 1));

  assign diff_left    = (SW + 1)'(cur_left_r) - (SW + 1)'(prev_left_r);
  assign diff_right   = (SW + 1)'(cur_right_r) - (SW + 1)'(prev_right_r);
  assign phase_frac   = $signed({1'b0, phase_r[PF:0]});
  assign lerp_left    = lerp_finish(prev_left_r, prod_left_r);
  assign lerp_right   = lerp_finish(prev_right_r, prod_right_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !out_tready);
      if (clear_state) begin
        phase_r      <= '0;
        prev_left_r  <= '0;
        prev_right_r <= '0;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (q_pop) begin
              if (q_rdata.pass_through) begin
                out_left_r  <= q_rdata.sample_l;
                out_right_r <= q_rdata.sample_r;
                out_last_r  <= 1'b1;
              end else if (phase_ge_one) begin
                // No output falls in this interval.
                phase_r      <= phase_r - {3'b001, {PF{1'b0}}};
                prev_left_r  <= q_rdata.sample_l;
                prev_right_r <= q_rdata.sample_r;
              end else begin
                cur_left_r  <= q_rdata.sample_l;
                cur_right_r <= q_rdata.sample_r;
                cnt_r       <= '0;
                state_r     <= S_MUL;
              end
            end
          end
          S_MUL: begin
            prod_left_r  <= PW'(diff_left) * PW'(phase_frac);
            prod_right_r <= PW'(diff_right) * PW'(phase_frac);
            state_r      <= S_OUT;
          end
          S_OUT: begin
            if (slot_free) begin
              out_left_r  <= lerp_left;
              out_right_r <= lerp_right;
              out_last_r  <= final_out;
              cnt_r       <= cnt_r + CW'(1);
              if (final_out) begin
                phase_r      <= nxt_ge_one ? (phase_nxt - {3'b001, {PF{1'b0}}}) : '0;
                prev_left_r  <= cur_left_r;
                prev_right_r <= cur_right_r;
                state_r      <= S_IDLE;
              end else begin
                phase_r <= phase_nxt;
                state_r <= S_MUL;
              end
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = out_last_r;

endmodule

### test/resampler_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the resampler, keeps its own
// copy of the phase accumulator and the previous frame, and compares each output
// request with the oldest output that it has worked out.
module resampler_checker
  import lrs48_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [2*SAMPLE_W-1:0]     in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [2*SAMPLE_W-1:0]     out_tdata,
  input  logic                      out_tlast,
  output int                        mismatch_count,
  output int                        pending
);

  localparam int PH_W = PHASE_FRAC_BITS + 3;
  localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << PHASE_FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } stereo_out_t;

  stereo_out_t                due_outputs[$];
  int                         errs = 0;
  logic [RATE_W-1:0]          rate_reg;
  logic                       stereo_reg;
  logic [PH_W-1:0]            phase;
  logic [PH_W-1:0]            phase_step;
  logic signed [SAMPLE_W-1:0] prev_l;
  logic signed [SAMPLE_W-1:0] prev_r;

  assign mismatch_count = errs;

  // A zero rate behaves as 48 kHz.
  function automatic logic [PH_W-1:0] step_for(input logic [RATE_W-1:0] rate);
    longint unsigned r;
    r = (rate == 0) ? longint'(TARGET_RATE_HZ) : longint'(rate);
    return PH_W'((r << PHASE_FRAC_BITS) / longint'(TARGET_RATE_HZ));
  endfunction

  // prev + (cur - prev) * phase, truncated toward zero.
  function automatic logic signed [SAMPLE_W-1:0] lerp_sample(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [PH_W-1:0]            ph
  );
    longint one;
    longint acc;
    one = longint'(1) << PHASE_FRAC_BITS;
    acc = longint'(a) * one + (longint'(b) - longint'(a)) * longint'({1'b0, ph});
    return SAMPLE_W'(acc / one);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    errs++;
  endtask

  task automatic predict_frame(input logic [2*SAMPLE_W-1:0] data);
    logic signed [SAMPLE_W-1:0] cur_l;
    logic signed [SAMPLE_W-1:0] cur_r;
    stereo_out_t                f;
    int                         n;
    cur_l = data[SAMPLE_W-1:0];
    cur_r = stereo_reg ? data[2*SAMPLE_W-1:SAMPLE_W] : cur_l;
    if (rate_reg == 0 || rate_reg == RATE_W'(TARGET_RATE_HZ)) begin
      // Straight through; the interpolation state is left alone.
      f.left  = cur_l;
      f.right = cur_r;
      f.last  = 1'b1;
      due_outputs.push_back(f);
      return;
    end
    n = 0;
    while (phase < PHASE_ONE && n < MAX_OUT) begin
      f.left  = lerp_sample(prev_l, cur_l, phase);
      f.right = lerp_sample(prev_r, cur_r, phase);
      f.last  = 1'b0;
      due_outputs.push_back(f);
      n++;
      phase = phase + phase_step;
    end
    if (n > 0) begin
      f = due_outputs.pop_back();
      f.last = 1'b1;
      due_outputs.push_back(f);
    end
    // Below the supported rates the output cap can stop the loop early; the
    // phase then clamps at zero.
    phase  = (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
    prev_l = cur_l;
    prev_r = cur_r;
  endtask

  always @(posedge clk) begin
    stereo_out_t exp;
    if (!rst_n) begin
      rate_reg   = RATE_W'(TARGET_RATE_HZ);
      stereo_reg = 1'b1;
      phase_step = step_for(RATE_W'(TARGET_RATE_HZ));
      phase      = '0;
      prev_l     = '0;
      prev_r     = '0;
      due_outputs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SOURCE_RATE) begin
          rate_reg   = cfg_wdata[RATE_W-1:0];
          phase_step = step_for(rate_reg);
          phase      = '0;
          prev_l     = '0;
          prev_r     = '0;
        end else if (cfg_index == REG_STEREO_INPUT) begin
          stereo_reg = cfg_wdata[0];
          phase      = '0;
          prev_l     = '0;
          prev_r     = '0;
        end
      end
      // Outputs are checked before this edge's input is predicted, so an output
      // can never be matched against a frame that is only now arriving.
      if (out_tvalid && out_tready) begin
        if (due_outputs.size() == 0) begin
          flag_mismatch($sformatf("unexpected output %h last %b", out_tdata, out_tlast));
        end else begin
          exp = due_outputs.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== exp.left) begin
            flag_mismatch($sformatf("left %h, expected %h",
                                    out_tdata[SAMPLE_W-1:0], exp.left));
          end
          if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== exp.right) begin
            flag_mismatch($sformatf("right %h, expected %h",
                                    out_tdata[2*SAMPLE_W-1:SAMPLE_W], exp.right));
          end
          if (out_tlast !== exp.last) begin
            flag_mismatch($sformatf("tlast %b, expected %b", out_tlast, exp.last));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_frame(in_tdata);
      end
    end
    pending <= due_outputs.size();
  end

endmodule

### test/linear_resampler_to_48k_stereo_top_tb.sv
`timescale 1ns / 1ps

// Testbench top for the 48 kHz stereo resampler. This module only makes stimulus
// and gives the verdict; the checker beside the block predicts every output.
module linear_resampler_to_48k_stereo_top_tb;
  import lrs48_pkg::*;

  // Register indexes that decode to nothing; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

  // The drain covers a frame still at work in the back end and the two more that the
  // internal queue holds, so any frame that produces no output has finished as well.
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 10;
  localparam int ITEMS_PER_PHASE = 25;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_tvalid;
  logic                      in_tready;
  // From bit 0 up: left_sample[15:0], right_sample[15:0].
  logic [2*SAMPLE_W-1:0]     in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  // From bit 0 up: out_left[15:0], out_right[15:0].
  logic [2*SAMPLE_W-1:0]     out_tdata;
  logic                      out_tlast;

  int                        mismatch_count;
  int                        pending;

  // Shared between the stimulus process and the receiver process.
  bit                        quiet;     // no idling on either side
  bit                        hold_req;  // ask the receiver for one long hold-off

  linear_resampler_to_48k_stereo_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  resampler_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block stops producing outputs or stalls its input.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random bursts of ready and, outside quiet mode, of stall. On
  // request it holds ready low for a long stretch so that the internal queue fills
  // and the block has to stall its input.
  initial begin
    out_tready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Full-scale extremes show up often, since they stress the interpolation
  // product the most.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offers one frame and waits for the edge where the request is accepted. Valid
  // stays high into the next call unless an idle burst follows; the task waits that out.
  task automatic push_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    do @(posedge clk); while (!in_tready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Brings the block to idle: no input offered, every predicted output delivered,
  // then enough cycles for a frame that makes no output to finish as well. The
  // first edge lets the checker's count catch up with the last accepted frame.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable drops on the following edge so that two writes
  // in a row never lower and raise it within one time step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [RATE_W-1:0] rate;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the rate is 48 kHz, so frames pass straight
    // through, extremes on both channels.
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h0000, 16'hFFFF);
    push_frame(16'hFFFF, 16'h0001);

    // A zero rate also means pass-through.
    settle();
    cfg_write(REG_SOURCE_RATE, '0);
    push_frame(16'h1234, 16'hEDCB);
    push_frame(16'h8000, 16'h8000);

    // Lowest supported rate: eight outputs per frame, full-scale swings between
    // consecutive frames.
    settle();
    cfg_write(REG_SOURCE_RATE, CFG_DATA_W'(6000));
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h1234, 16'hEDCB);

    // Highest supported rate: one output, then frames that produce none.
    settle();
    cfg_write(REG_SOURCE_RATE, CFG_DATA_W'(192000));
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h4000, 16'hC000);
    push_frame(16'hC000, 16'h4000);

    // Mono with a rate far below the supported range: the output cap cuts every
    // frame short and the right sample must be ignored.
    settle();
    cfg_write(REG_STEREO_INPUT, '0);
    cfg_write(REG_SOURCE_RATE, CFG_DATA_W'(1000));
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h0100, 16'hFFFF);

    // Writes to unmapped indexes must change nothing, not even the phase.
    settle();
    cfg_write(REG_UNMAPPED_2, '1);
    cfg_write(REG_UNMAPPED_3, CFG_DATA_W'(48000));
    push_frame(16'h8000, 16'h1111);
    push_frame(16'h7FFF, 16'h2222);

    // Random part: a new setting per phase, then a run of random frames. The last
    // phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 9))
        0:       rate = RATE_W'(TARGET_RATE_HZ);
        1:       rate = '0;
        2:       rate = RATE_W'(6000);
        3:       rate = RATE_W'(192000);
        4:       rate = '1;
        5:       rate = RATE_W'($urandom_range(1, 5999));
        6:       rate = RATE_W'(44100);
        default: rate = RATE_W'($urandom_range(6000, 192000));
      endcase
      // The long hold-off wants a rate with several outputs per frame.
      if (p == 2) begin
        rate = RATE_W'(8000);
      end
      cfg_write(REG_SOURCE_RATE, CFG_DATA_W'(rate));
      cfg_write(REG_STEREO_INPUT, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
                  CFG_DATA_W'($urandom));
      end
      quiet = (p == RANDOM_PHASES - 1);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        push_frame(pick_sample(), pick_sample());
      end
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
